// ----- rtl/core/first_fit_block_allocator_defines.svh -----
// assertion macros used by the allocator controller rtl
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFBA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication
`define FFBA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// ----- rtl/core/ffba_pkg.sv -----
package ffba_pkg;

   localparam int MAX_BLOCKS_DEF = 64;
   localparam int ADDR_BITS_DEF  = 16;

   localparam int LEN_BITS     = 17;
   localparam int OWNER_BITS   = 8;
   localparam int FADDR_BITS   = 16;
   localparam int RADDR_BITS   = 16;
   localparam int STATUS_BITS  = 2;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [LEN_BITS-1:0] HEAP_LIMIT      = 17'd65536;
   localparam logic [LEN_BITS-1:0] MIN_SPLIT_RESET = 17'd16;

   localparam logic [CSR_IDX_BITS-1:0] REG_HEAP      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_SPLIT = 2'd1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      RSP_OK        = 2'd0,
      RSP_NO_FIT    = 2'd1,
      RSP_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic                  req_type;
      logic [LEN_BITS-1:0]   req_size;
      logic [OWNER_BITS-1:0] user_id;
      logic [FADDR_BITS-1:0] free_addr;
   } req_beat_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [RADDR_BITS-1:0]  result_addr;
      logic [LEN_BITS-1:0]    used_bytes;
      logic [LEN_BITS-1:0]    free_bytes;
   } rsp_beat_type;

   typedef struct packed {
      logic                  valid;
      logic                  is_free;
      logic [LEN_BITS-1:0]   len;
      logic [OWNER_BITS-1:0] owner;
   } slot_type;

   typedef struct packed {
      logic shift;
      logic init;
   } chain_ctl_type;

endpackage

// ----- rtl/core/first_fit_block_allocator.sv -----
// an accepted start scans the whole cell chain, then raises the rsp_valid strobe
// a new request is taken only after the previous one ends, as its scan is one full rotation of the cell chain
// busy is high while the cell chain is scanned; start is taken again in the strobe cycle
// the result strobe lasts one cycle and cannot be stalled
// synchronous reset: one free block of 65536 bytes at address 0, min split 16
// a heap_bytes write restarts the heap as one free block at address 0 of the written size, clamped to 1..65536
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ffba_pkg::req_beat_type            req_beat,
   output logic                              rsp_valid,
   output ffba_pkg::rsp_beat_type            rsp_beat,
   input  logic                              csr_we,
   input  logic [ffba_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ffba_pkg::LEN_BITS-1:0]     csr_wdata
);

   logic [ADDR_BITS-1:0]        cell_base [MAX_BLOCKS];
   ffba_pkg::slot_type          cell_slot [MAX_BLOCKS];
   logic [ADDR_BITS-1:0]        tail_base;
   ffba_pkg::slot_type          tail_slot;
   ffba_pkg::chain_ctl_type     chain_ctl;
   logic [ffba_pkg::LEN_BITS-1:0] init_len;

   ffba_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .head_base (cell_base[0]),
      .head_slot (cell_slot[0]),
      .tail_base (tail_base),
      .tail_slot (tail_slot),
      .chain_ctl (chain_ctl),
      .init_len  (init_len)
   );

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      logic [ADDR_BITS-1:0] nb_base;
      ffba_pkg::slot_type   nb_slot;
      ffba_pkg::slot_type   init_slot;

      if (i == MAX_BLOCKS - 1) begin : g_tail
         assign nb_base = tail_base;
         assign nb_slot = tail_slot;
      end else begin : g_mid
         assign nb_base = cell_base[i+1];
         assign nb_slot = cell_slot[i+1];
      end

      // entry 0 holds the whole heap after init, the rest are empty
      if (i == 0) begin : g_first
         assign init_slot = '{valid: 1'b1, is_free: 1'b1, len: init_len, owner: '0};
      end else begin : g_rest
         assign init_slot = '0;
      end

      ffba_cell #(
         .ADDR_BITS (ADDR_BITS)
      ) u_cell (
         .clock     (clock),
         .chain_ctl (chain_ctl),
         .init_base ('0),
         .init_slot (init_slot),
         .in_base   (nb_base),
         .in_slot   (nb_slot),
         .out_base  (cell_base[i]),
         .out_slot  (cell_slot[i])
      );
   end

endmodule

// ----- rtl/core/ffba_cell.sv -----
module ffba_cell #(
   parameter int ADDR_BITS = ffba_pkg::ADDR_BITS_DEF
) (
   input  logic                     clock,
   input  ffba_pkg::chain_ctl_type  chain_ctl,
   input  logic [ADDR_BITS-1:0]     init_base,
   input  ffba_pkg::slot_type       init_slot,
   input  logic [ADDR_BITS-1:0]     in_base,
   input  ffba_pkg::slot_type       in_slot,
   output logic [ADDR_BITS-1:0]     out_base,
   output ffba_pkg::slot_type       out_slot
);

   logic [ADDR_BITS-1:0] base_ff;
   logic [ADDR_BITS-1:0] base_in;
   ffba_pkg::slot_type   slot_ff;
   ffba_pkg::slot_type   slot_in;

   always_comb begin
      base_in = base_ff;
      slot_in = slot_ff;
      if (chain_ctl.init) begin
         base_in = init_base;
         slot_in = init_slot;
      end else if (chain_ctl.shift) begin
         base_in = in_base;
         slot_in = in_slot;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      slot_ff <= slot_in;
   end

   assign out_base = base_ff;
   assign out_slot = slot_ff;

endmodule

// ----- rtl/core/ffba_ctrl.sv -----
`include "first_fit_block_allocator_defines.svh"

module ffba_ctrl #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  ffba_pkg::req_beat_type               req_beat,
   output logic                                 rsp_valid,
   output ffba_pkg::rsp_beat_type               rsp_beat,
   input  logic                                 csr_we,
   input  logic [ffba_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ffba_pkg::LEN_BITS-1:0]        csr_wdata,
   input  logic [ADDR_BITS-1:0]                 head_base,
   input  ffba_pkg::slot_type                   head_slot,
   output logic [ADDR_BITS-1:0]                 tail_base,
   output ffba_pkg::slot_type                   tail_slot,
   output ffba_pkg::chain_ctl_type              chain_ctl,
   output logic [ffba_pkg::LEN_BITS-1:0]        init_len
);

   localparam int SW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int LW = ffba_pkg::LEN_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [LW-1:0]          used_ff, used_in;
   logic [LW-1:0]          heap_ff, heap_in;
   logic [LW-1:0]          msplit_ff, msplit_in;
   ffba_pkg::req_beat_type req_ff, req_in;
   logic                   found_ff, found_in;
   logic                   pend_ff, pend_in;
   logic [ADDR_BITS-1:0]   pend_base_ff, pend_base_in;
   logic [LW-1:0]          pend_len_ff, pend_len_in;
   logic [ADDR_BITS-1:0]   raddr_ff, raddr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_beat_type rsp_ff, rsp_in;

   logic          scanning;
   logic          accept;
   logic          step_last;
   logic          heap_wr;
   logic [LW-1:0] heap_clamp;
   logic          fit;
   logic          hit_free;
   logic [LW-1:0] rem;
   logic          do_split;
   logic          append;
   logic [LW-1:0] grant_len;

   assign scanning  = (state_ff == ST_SCAN);
   assign busy      = scanning;
   assign accept    = start && !busy;
   assign step_last = (step_ff == SW'(MAX_BLOCKS - 1));
   assign heap_wr   = csr_we && (csr_index == ffba_pkg::REG_HEAP);

   always_comb begin
      heap_clamp = csr_wdata;
      if (csr_wdata == '0) begin
         heap_clamp = LW'(1);
      end else if (csr_wdata > ffba_pkg::HEAP_LIMIT) begin
         heap_clamp = ffba_pkg::HEAP_LIMIT;
      end
   end

   assign chain_ctl.init  = reset || heap_wr;
   assign chain_ctl.shift = scanning;
   assign init_len        = reset ? ffba_pkg::HEAP_LIMIT : heap_clamp;

   // head cell evaluation
   assign fit = scanning && !found_ff && head_slot.valid && head_slot.is_free
                && (req_ff.req_type == ffba_pkg::REQ_ALLOC)
                && (req_ff.req_size != '0) && (head_slot.len >= req_ff.req_size);
   assign hit_free = scanning && !found_ff && head_slot.valid && !head_slot.is_free
                     && (req_ff.req_type == ffba_pkg::REQ_FREE)
                     && (32'(head_base) == 32'(req_ff.free_addr));
   assign rem       = head_slot.len - req_ff.req_size;
   assign do_split  = fit && (rem != '0) && (rem >= msplit_ff)
                      && (count_ff < CW'(MAX_BLOCKS));
   assign append    = scanning && pend_ff && (CW'(step_ff) == count_ff);
   assign grant_len = do_split ? req_ff.req_size : head_slot.len;

   always_comb begin
      tail_base = head_base;
      tail_slot = head_slot;
      if (fit) begin
         tail_slot.is_free = 1'b0;
         tail_slot.owner   = req_ff.user_id;
         tail_slot.len     = grant_len;
      end else if (hit_free) begin
         tail_slot.is_free = 1'b1;
         tail_slot.owner   = '0;
      end else if (append) begin
         tail_base         = pend_base_ff;
         tail_slot.valid   = 1'b1;
         tail_slot.is_free = 1'b1;
         tail_slot.len     = pend_len_ff;
         tail_slot.owner   = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      heap_in      = heap_ff;
      msplit_in    = msplit_ff;
      req_in       = req_ff;
      found_in     = found_ff;
      pend_in      = pend_ff;
      pend_base_in = pend_base_ff;
      pend_len_in  = pend_len_ff;
      raddr_in     = raddr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (accept) begin
         state_in = ST_SCAN;
         step_in  = '0;
         req_in   = req_beat;
         found_in = 1'b0;
         pend_in  = 1'b0;
         raddr_in = '0;
      end

      if (scanning) begin
         step_in  = step_ff + SW'(1);
         found_in = found_ff || fit || hit_free;
         if (fit) begin
            raddr_in = head_base;
            used_in  = used_ff + grant_len;
         end else if (hit_free) begin
            used_in = used_ff - head_slot.len;
         end
         if (do_split) begin
            pend_in      = 1'b1;
            pend_base_in = head_base + ADDR_BITS'(req_ff.req_size);
            pend_len_in  = rem;
         end
         if (step_last) begin
            state_in           = ST_IDLE;
            count_in           = count_ff + CW'(pend_ff);
            rsp_valid_in       = 1'b1;
            rsp_in.result_addr = ffba_pkg::RADDR_BITS'(fit ? head_base : raddr_ff);
            rsp_in.used_bytes  = used_in;
            rsp_in.free_bytes  = heap_ff - used_in;
            if (found_ff || fit || hit_free) begin
               rsp_in.status = ffba_pkg::RSP_OK;
            end else if (req_ff.req_type == ffba_pkg::REQ_ALLOC) begin
               rsp_in.status = ffba_pkg::RSP_NO_FIT;
            end else begin
               rsp_in.status = ffba_pkg::RSP_NOT_FOUND;
            end
         end
      end

      if (heap_wr) begin
         heap_in  = heap_clamp;
         used_in  = '0;
         count_in = CW'(1);
      end
      if (csr_we && (csr_index == ffba_pkg::REG_MIN_SPLIT)) begin
         msplit_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= CW'(1);
         used_ff      <= '0;
         heap_ff      <= ffba_pkg::HEAP_LIMIT;
         msplit_ff    <= ffba_pkg::MIN_SPLIT_RESET;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         heap_ff      <= heap_in;
         msplit_ff    <= msplit_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pend_base_ff <= pend_base_in;
      pend_len_ff  <= pend_len_in;
      raddr_ff     <= raddr_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   `FFBA_ASSERT_NXT(a_accept_scan, clock, reset, accept, scanning && step_ff == '0)
   `FFBA_ASSERT_IMP(a_rsp_after_last, clock, reset, rsp_valid_ff, $past(scanning && step_last))
   `FFBA_ASSERT_IMP(a_used_in_heap, clock, reset, 1'b1, used_ff <= heap_ff)
   `FFBA_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff != '0 && count_ff <= CW'(MAX_BLOCKS))

endmodule
